// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define DQSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset
`define DQSA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/dqsa_pkg.sv =====
// Types and constants of the dual queue shared array
package dqsa_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic {
    SIDE_FRONT = 1'b0,
    SIDE_BACK  = 1'b1
  } side_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic take_upper;
    logic take_lower;
  } cell_ctrl_t;

endpackage

// ===== rtl/dqsa_cell.sv =====
// One storage cell of the shared array chain
module dqsa_cell import dqsa_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [WORD_W-1:0] load_data_i,
  input  logic signed [WORD_W-1:0] upper_i,
  input  logic signed [WORD_W-1:0] lower_i,
  output logic signed [WORD_W-1:0] q_o
);

  logic signed [WORD_W-1:0] word_q;
  logic signed [WORD_W-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = load_data_i;
    end else if (ctrl_i.take_upper) begin
      word_d = upper_i;
    end else if (ctrl_i.take_lower) begin
      word_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign q_o = word_q;

endmodule

// ===== rtl/dual_queue_shared_array.sv =====
// Top level: two queues sharing one chain of storage cells
//
//   channel | direction | valid       | stall        | payload
//   in      | into      | in_valid_i  | in_stall_o   | func_i, side_i, data_in_i
//   out     | out of    | out_valid_o | out_stall_i  | data_out_o, status_o
//
// One transaction per cycle unless stalled; a dequeue shifts queue cells in parallel.
// The result appears on the output register the cycle after acceptance.
// A new transaction is taken while the output register is empty or being drained.
// Reset clears both queue counts and the output valid; cell contents are left as is.
// A stalled output holds its transaction and stalls the input side.
module dual_queue_shared_array import dqsa_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic                     side_i,
  input  logic signed [WORD_W-1:0] data_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] data_out_o,
  output logic [1:0]               status_o
);

`include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         front_count_q, front_count_d;
  logic [CNT_W-1:0]         back_count_q, back_count_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [WORD_W-1:0] data_out_q, data_out_d;
  status_e                  status_q, status_d;

  logic                     in_fire;
  logic                     full;
  logic                     enq_front, enq_back, deq_front, deq_back;
  logic [CNT_W:0]           total;
  logic signed [WORD_W-1:0] cell_q [DEPTH];
  cell_ctrl_t               cell_ctrl [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign total      = {1'b0, front_count_q} + {1'b0, back_count_q};
  assign full       = total >= (CNT_W + 1)'(DEPTH);

  assign enq_front = in_fire && (func_i == FUNC_ENQ) && (side_i == SIDE_FRONT) && !full;
  assign enq_back  = in_fire && (func_i == FUNC_ENQ) && (side_i == SIDE_BACK) && !full;
  assign deq_front = in_fire && (func_i == FUNC_DEQ) && (side_i == SIDE_FRONT)
                     && (front_count_q != '0);
  assign deq_back  = in_fire && (func_i == FUNC_DEQ) && (side_i == SIDE_BACK)
                     && (back_count_q != '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] upper;
    logic signed [WORD_W-1:0] lower;

    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_up
      assign upper = cell_q[i+1];
    end

    if (i == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_dn
      assign lower = cell_q[i-1];
    end

    always_comb begin
      cell_ctrl[i].load = (enq_front && (front_count_q == CNT_W'(i)))
                       || (enq_back && (back_count_q == CNT_W'(DEPTH - 1 - i)));
      cell_ctrl[i].take_upper = deq_front && (CNT_W'(i + 1) < front_count_q);
      cell_ctrl[i].take_lower = deq_back && (CNT_W'(DEPTH - i) < back_count_q);
    end

    dqsa_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .load_data_i (data_in_i),
      .upper_i     (upper),
      .lower_i     (lower),
      .q_o         (cell_q[i])
    );
  end

  always_comb begin
    front_count_d = front_count_q;
    back_count_d  = back_count_q;
    if (enq_front) begin
      front_count_d = front_count_q + CNT_W'(1);
    end else if (enq_back) begin
      back_count_d = back_count_q + CNT_W'(1);
    end else if (deq_front) begin
      front_count_d = front_count_q - CNT_W'(1);
    end else if (deq_back) begin
      back_count_d = back_count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    data_out_d  = data_out_q;
    status_d    = status_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      data_out_d  = '0;
      status_d    = ST_DONE;
      if (func_i == FUNC_ENQ) begin
        if (full) begin
          status_d = ST_FULL;
        end
      end else if (side_i == SIDE_FRONT) begin
        if (deq_front) begin
          data_out_d = cell_q[0];
        end else begin
          status_d = ST_EMPTY;
        end
      end else begin
        if (deq_back) begin
          data_out_d = cell_q[DEPTH-1];
        end else begin
          status_d = ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_count_q <= '0;
      back_count_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      front_count_q <= front_count_d;
      back_count_q  <= back_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_out_q <= data_out_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;

  `DQSA_ASSERT(a_counts_fit, total <= (CNT_W + 1)'(DEPTH), "queue counts exceed depth")
  `DQSA_ASSERT_IMP(a_front_enq_count, enq_front, front_count_q == $past(front_count_q) + CNT_W'(1), "front count did not advance")
  `DQSA_ASSERT_IMP(a_empty_status, in_fire && (func_i == FUNC_DEQ) && (side_i == SIDE_FRONT) && (front_count_q == '0), status_q == ST_EMPTY, "empty front dequeue not flagged")
  `DQSA_ASSERT(a_zero_on_fail, !(out_valid_q && (status_q != ST_DONE)) || (data_out_q == '0), "failed transaction carries data")

endmodule

// ===== tb/tb_dual_queue_shared_array.sv =====
// Testbench for dual_queue_shared_array: random and directed queue operations
module tb_dual_queue_shared_array import dqsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8;
  localparam int N_RANDOM = 1200;
  localparam int HOLD_AT = 1000;
  localparam int HOLD_LEN = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    func_e                     func;
    side_e                     side;
    logic signed [WORD_W-1:0] word;
    bit                        drain;
  } queue_op_t;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    status_e                   status;
  } queue_res_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     func_i = 1'b0;
  logic                     side_i = 1'b0;
  logic signed [WORD_W-1:0] data_in_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [WORD_W-1:0] data_out_o;
  logic [1:0]               status_o;

  queue_op_t  pending_ops[$];
  queue_res_t expected_results[$];

  logic [WORD_W-1:0] slot[DEPTH];
  int front_n = 0;
  int back_n = 0;
  int peak_fill = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_taken = 0;
  int n_sent = 0;
  int n_done = 0;
  int n_errors = 0;

  dual_queue_shared_array #(.DEPTH(DEPTH)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .side_i     (side_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_out_o (data_out_o),
    .status_o   (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic queue_res_t apply_op(queue_op_t op);
    queue_res_t r;
    r.word = '0;
    r.status = ST_DONE;
    if (op.func == FUNC_ENQ) begin
      if (front_n + back_n >= DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else if (op.side == SIDE_FRONT) begin
        slot[front_n] = op.word;
        front_n++;
      end else begin
        slot[DEPTH - 1 - back_n] = op.word;
        back_n++;
      end
      if (front_n + back_n > peak_fill) peak_fill = front_n + back_n;
    end else if (op.side == SIDE_FRONT) begin
      if (front_n == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.word = slot[0];
        for (int i = 0; i + 1 < front_n; i++) slot[i] = slot[i + 1];
        front_n--;
        n_taken++;
      end
    end else begin
      if (back_n == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.word = slot[DEPTH - 1];
        for (int i = DEPTH - 1; i > DEPTH - back_n; i--) slot[i] = slot[i - 1];
        back_n--;
        n_taken++;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic queue_op_t make_op(func_e f, side_e s, logic [WORD_W-1:0] w);
    queue_op_t op;
    op.func = f;
    op.side = s;
    op.word = w;
    op.drain = 1'b0;
    return op;
  endfunction

  // driver
  int send_gap = 0;
  int send_cyc = 0;
  always @(posedge clk_i) begin
    logic take;
    queue_op_t op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      send_cyc++;
      take = in_valid_i && !in_stall_o;
      if (take) begin
        op.func = func_e'(func_i);
        op.side = side_e'(side_i);
        op.word = data_in_i;
        op.drain = 1'b0;
        expected_results.push_back(apply_op(op));
        n_sent++;
        send_gap = pick_gap((send_cyc / 300) % 5 == 0);
      end
      if (!in_valid_i || take) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_ops[0].drain) begin
          if (!take && n_sent == n_done) void'(pending_ops.pop_front());
          in_valid_i <= 1'b0;
        end else begin
          op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          func_i <= op.func;
          side_i <= op.side;
          data_in_i <= op.word;
        end
      end
    end
  end

  // receiver stall, with one long hold
  int stall_left = 0;
  int hold_left = 0;
  int recv_cyc = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      recv_cyc++;
      if (recv_cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap((recv_cyc / 350) % 4 == 1);
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    queue_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_done <= n_done + 1;
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR unexpected transaction: data_out %0d status %0d", data_out_o, status_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (data_out_o !== exp_res.word || status_o !== exp_res.status) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR at %0t: data_out exp %0d got %0d, status exp %0d got %0d",
                     $realtime, exp_res.word, data_out_o, exp_res.status, status_o);
        end
      end
    end
  end

  initial begin
    queue_op_t drain_op;
    int n_made;
    int seg_len;
    int enq_pct;
    int side_mode;
    side_e s;

    drain_op = make_op(FUNC_DEQ, SIDE_FRONT, '0);
    drain_op.drain = 1'b1;

    pending_ops.push_back(make_op(FUNC_DEQ, SIDE_FRONT, 32'h1234_5678));
    pending_ops.push_back(make_op(FUNC_DEQ, SIDE_BACK, 32'hffff_ffff));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_FRONT, 32'h7fff_ffff));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_BACK, 32'hffff_ffff));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_FRONT, 32'h8000_0000));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_BACK, 32'h0000_0000));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_FRONT, 32'h0000_0001));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_BACK, 32'haaaa_aaaa));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_FRONT, 32'h5555_5555));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_BACK, 32'hffff_fffe));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_FRONT, 32'h0bad_f00d));
    pending_ops.push_back(make_op(FUNC_ENQ, SIDE_BACK, 32'h0bad_f00d));
    for (int k = 0; k < 5; k++) pending_ops.push_back(make_op(FUNC_DEQ, SIDE_FRONT, '0));
    for (int k = 0; k < 5; k++) pending_ops.push_back(make_op(FUNC_DEQ, SIDE_BACK, '1));
    pending_ops.push_back(drain_op);

    n_made = 0;
    while (n_made < N_RANDOM) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 85;
      endcase
      side_mode = $urandom_range(0, 3);
      for (int k = 0; k < seg_len && n_made < N_RANDOM; k++) begin
        if (side_mode == 0) s = SIDE_FRONT;
        else if (side_mode == 1) s = SIDE_BACK;
        else s = side_e'($urandom_range(0, 1));
        pending_ops.push_back(make_op(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                                      s, rand_word()));
        n_made++;
        if (n_made == N_RANDOM / 2) pending_ops.push_back(drain_op);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i || n_sent != n_done) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Ran %0d transactions: %0d dequeues returned data, %0d refused full, %0d on empty",
             n_sent, n_taken, n_full, n_empty);
    $display("Peak fill %0d of %0d slots, %0d output errors", peak_fill, DEPTH, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dqsa_pkg.sv
rtl/dqsa_cell.sv
rtl/dual_queue_shared_array.sv
tb/tb_dual_queue_shared_array.sv
